FILE: rtl/xcff_pkg.sv
// xcff_pkg: shared types and constants of the xor checked frame filter.
// Register indexes, reset values and result status codes.
// No dependencies.
`timescale 1ns / 1ps

package xcff_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_HEADER_BYTE    = 2'd0;
   localparam logic [1:0] CSR_FRAME_LENGTH   = 2'd1;
   localparam logic [1:0] CSR_PREFIX_COUNT   = 2'd2;
   localparam logic [1:0] CSR_PREFIX_PATTERN = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   // register reset values
   localparam logic [7:0]  HEADER_BYTE_RESET    = 8'h92;
   localparam logic [6:0]  FRAME_LENGTH_RESET   = 7'd35;
   localparam logic [1:0]  PREFIX_COUNT_RESET   = 2'd3;
   localparam logic [23:0] PREFIX_PATTERN_RESET = 24'h02020F;

   // shortest frame: header and checksum
   localparam int MIN_FRAME = 2;

   // result status codes
   typedef logic [1:0] status_type;
   localparam status_type STATUS_GOOD     = 2'd0;
   localparam status_type STATUS_PREFIX   = 2'd1;
   localparam status_type STATUS_CHECKSUM = 2'd2;

endpackage

FILE: rtl/xcff_if.sv
// xcff channel interfaces: received bytes, frame results, configuration writes.
// Valid/ready handshake; depends on xcff_pkg for payload widths.
`timescale 1ns / 1ps

interface xcff_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface xcff_rsp_if;
   logic                  valid;
   logic                  ready;
   logic [7:0]            frame_byte;
   xcff_pkg::status_type  status;
   logic                  last;

   modport source (output valid, output frame_byte, output status, output last,
                   input ready);
   modport sink   (input valid, input frame_byte, input status, input last,
                   output ready);
endinterface

interface xcff_csr_if;
   logic                            valid;
   logic                            ready;
   logic [xcff_pkg::CSR_INDEX_W-1:0] index;
   logic [xcff_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/xcff_frame_ram.sv
// xcff_frame_ram: frame byte store, one write and one registered read port.
// Read data is registered and appears in the cycle after the read enable. No dependencies.
`timescale 1ns / 1ps

module xcff_frame_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // store a byte
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/xor_checked_frame_filter_core.sv
// xor_checked_frame_filter_core: fixed-length frame receiver with XOR checksum.
// Input: one byte per cycle while collecting; a completing byte waits for a free output
// register, then gives an error result in the next cycle or starts store readout.
// Readout: each byte passes a store read state, then an output load state that waits
// for a free output register; input is held off until the readout ends.
// Reset (synchronous): config registers take reset values, counters clear; no payload reset or store sweep.
`timescale 1ns / 1ps

module xor_checked_frame_filter_core #(
   parameter int MAX_FRAME = 64
) (
   input  logic   clock,
   input  logic   reset,
   xcff_req_if.sink   req_ch,
   xcff_rsp_if.source rsp_ch,
   xcff_csr_if.sink   csr_ch
);

   localparam int IW = (MAX_FRAME > 2) ? $clog2(MAX_FRAME) : 1;
   localparam int CW = $clog2(MAX_FRAME + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   // configuration registers
   logic [7:0]  header_ff;
   logic [6:0]  length_ff;
   logic [1:0]  pcount_ff;
   logic [23:0] pattern_ff;

   // frame state
   logic [1:0]    state_ff, state_in;
   logic [IW-1:0] count_ff, count_in;
   logic [7:0]    xor_ff, xor_in;
   logic          pbad_ff, pbad_in;
   logic [IW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [IW-1:0] last_idx_ff, last_idx_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   xcff_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [8:0]    len9;
   logic [CW-1:0] len_eff;
   logic [CW-1:0] cnt_plus;
   logic [8:0]    count9;
   logic          completes;
   logic          out_free;
   logic          req_xfer;
   logic          drop;
   logic          pos_ok;
   logic [7:0]    pat_byte;
   logic          bad_now;
   logic          wr_en;
   logic          rd_en;
   logic [7:0]    rd_data;
   xcff_pkg::status_type done_status;

   // configuration writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff  <= xcff_pkg::HEADER_BYTE_RESET;
         length_ff  <= xcff_pkg::FRAME_LENGTH_RESET;
         pcount_ff  <= xcff_pkg::PREFIX_COUNT_RESET;
         pattern_ff <= xcff_pkg::PREFIX_PATTERN_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            xcff_pkg::CSR_HEADER_BYTE:    header_ff  <= csr_ch.data[7:0];
            xcff_pkg::CSR_FRAME_LENGTH:   length_ff  <= csr_ch.data[6:0];
            xcff_pkg::CSR_PREFIX_COUNT:   pcount_ff  <= csr_ch.data[1:0];
            xcff_pkg::CSR_PREFIX_PATTERN: pattern_ff <= csr_ch.data[23:0];
            default: ;
         endcase
      end
   end

   // clamp the frame length between the shortest frame and the store size
   always_comb begin
      if ({2'b00, length_ff} < 9'(xcff_pkg::MIN_FRAME)) begin
         len9 = 9'(xcff_pkg::MIN_FRAME);
      end else if ({2'b00, length_ff} > 9'(MAX_FRAME)) begin
         len9 = 9'(MAX_FRAME);
      end else begin
         len9 = {2'b00, length_ff};
      end
   end

   assign len_eff   = CW'(len9);
   assign cnt_plus  = CW'(count_ff) + CW'(1);
   assign count9    = 9'(count_ff);
   assign completes = (cnt_plus >= len_eff);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   // a completing byte may need the output register at once
   assign req_ch.ready = (state_ff == ST_IDLE) && (!completes || out_free);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign drop         = (count_ff == '0) && (req_ch.rx_byte != header_ff);

   // prefix compare for bytes one to prefix_count
   assign pos_ok = (count9 != 9'd0) && (count9 <= {7'd0, pcount_ff});

   always_comb begin
      case (count9[1:0])
         2'd1:    pat_byte = pattern_ff[23:16];
         2'd2:    pat_byte = pattern_ff[15:8];
         default: pat_byte = pattern_ff[7:0];
      endcase
   end

   assign bad_now = pbad_ff || (pos_ok && (pat_byte != req_ch.rx_byte));

   always_comb begin
      if (bad_now) begin
         done_status = xcff_pkg::STATUS_PREFIX;
      end else if (xor_ff != req_ch.rx_byte) begin
         done_status = xcff_pkg::STATUS_CHECKSUM;
      end else begin
         done_status = xcff_pkg::STATUS_GOOD;
      end
   end

   assign wr_en = req_xfer && !drop;
   assign rd_en = (state_ff == ST_READ);

   // collect, check, then sequence the readout
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      xor_in        = xor_ff;
      pbad_in       = pbad_ff;
      rd_ptr_in     = rd_ptr_ff;
      last_idx_in   = last_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (wr_en) begin
               if (!completes) begin
                  count_in = IW'(cnt_plus);
                  xor_in   = xor_ff ^ req_ch.rx_byte;
                  pbad_in  = bad_now;
               end else begin
                  count_in = '0;
                  xor_in   = 8'd0;
                  pbad_in  = 1'b0;
                  if (done_status != xcff_pkg::STATUS_GOOD) begin
                     rsp_valid_in  = 1'b1;
                     rsp_byte_in   = 8'd0;
                     rsp_status_in = done_status;
                     rsp_last_in   = 1'b1;
                  end else begin
                     state_in    = ST_READ;
                     rd_ptr_in   = '0;
                     last_idx_in = count_ff;
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = rd_data;
               rsp_status_in = xcff_pkg::STATUS_GOOD;
               rsp_last_in   = (rd_ptr_ff == last_idx_ff);
               if (rd_ptr_ff == last_idx_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_ptr_in = rd_ptr_ff + IW'(1);
                  state_in  = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         xor_ff       <= 8'd0;
         pbad_ff      <= 1'b0;
         rd_ptr_ff    <= '0;
         last_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         xor_ff       <= xor_in;
         pbad_ff      <= pbad_in;
         rd_ptr_ff    <= rd_ptr_in;
         last_idx_ff  <= last_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.frame_byte = rsp_byte_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.last       = rsp_last_ff;

   xcff_frame_ram #(
      .DEPTH  (MAX_FRAME),
      .ADDR_W (IW)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff),
      .wr_data (req_ch.rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   // readout never runs past the last stored byte
   a_ptr_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (rd_ptr_ff <= last_idx_ff))
      else $error("readout pointer beyond frame end");

   // frame counters stay clear during readout
   a_clear_in_readout: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (count_ff == '0 && xor_ff == 8'd0 && !pbad_ff))
      else $error("frame state not cleared during readout");

   // loading the final byte ends the readout with last set
   a_last_ends_readout: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && out_free && rd_ptr_ff == last_idx_ff)
      |=> (state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("final byte did not end readout");

   // an error result carries a zero byte and last
   a_error_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != xcff_pkg::STATUS_GOOD)
      |-> (rsp_byte_ff == 8'd0 && rsp_last_ff))
      else $error("malformed error result");

endmodule
